[rtl/core/dtq_pkg.sv]
package dtq_pkg;

  // Store and id-space sizes
  localparam int DELAYED_DEPTH  = 32;
  localparam int PERIODIC_DEPTH = 32;
  localparam int TASK_IDS       = 256;
  localparam int MAX_RESULTS    = 64;

  localparam int DLY_AW  = (DELAYED_DEPTH > 1) ? $clog2(DELAYED_DEPTH) : 1;
  localparam int PER_AW  = (PERIODIC_DEPTH > 1) ? $clog2(PERIODIC_DEPTH) : 1;
  localparam int IDX_W   = (DLY_AW > PER_AW) ? DLY_AW : PER_AW;
  localparam int MARK_AW = $clog2(TASK_IDS);
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

  // Queues between the channels and the engine
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_AW      = $clog2(CMDQ_DEPTH);
  localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 4;
  localparam int RQ_AW      = $clog2(RESQ_DEPTH);
  localparam int RQ_CW      = $clog2(RESQ_DEPTH + 1);

  localparam logic [9:0] TICK_MS_RESET = 10'd10;
  localparam logic [0:0] REG_TICK_MS   = 1'b0;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_ADD_DLY = 2'd1;
  localparam logic [1:0] FUNC_ADD_PER = 2'd2;
  localparam logic [1:0] FUNC_CANCEL  = 2'd3;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_DELAYED  = 2'd1;
  localparam logic [1:0] KIND_PERIODIC = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  task_id;
    logic [15:0] interval_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_task;
    logic       status;
    logic       last;
  } res_t;

  // Deadline relative to now, offset so that unsigned order is signed order
  function automatic logic [31:0] rel_key(input logic [31:0] due, input logic [31:0] now);
    rel_key = (due - now) ^ 32'h8000_0000;
  endfunction

  function automatic logic is_due(input logic [31:0] key);
    is_due = (key <= 32'h8000_0000);
  endfunction

  function automatic logic earlier(input logic [31:0] ka, input logic [15:0] sa,
                                   input logic [31:0] kb, input logic [15:0] sb);
    logic [15:0] d;
    d = sa - sb;
    earlier = (ka < kb) || ((ka == kb) && d[15]);
  endfunction

  function automatic logic id_ok(input logic [7:0] id);
    id_ok = (int'(id) < TASK_IDS);
  endfunction

endpackage

[rtl/core/dtq_front.sv]
module dtq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_func,
  input  logic [7:0]         in_task_id,
  input  logic [15:0]        in_interval_ms,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic               cmd_valid,
  output dtq_pkg::cmd_t      cmd,
  input  logic               cmd_pop,
  output logic [9:0]         tick_ms
);

  dtq_pkg::cmd_t                q_r [dtq_pkg::CMDQ_DEPTH];
  logic [dtq_pkg::CQ_AW-1:0]    wp_r, rp_r;
  logic [dtq_pkg::CQ_CW-1:0]    cnt_r;
  logic [9:0]                   tick_ms_r;
  logic                         push_ok, pop_ok, cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == dtq_pkg::REG_TICK_MS);
  assign prdata  = (paddr[2] == dtq_pkg::REG_TICK_MS) ? {22'd0, tick_ms_r} : 32'd0;
  assign tick_ms = tick_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ms_r <= dtq_pkg::TICK_MS_RESET;
    end else if (cfg_wr) begin
      tick_ms_r <= pwdata[9:0];
    end
  end

  assign in_full   = (cnt_r == dtq_pkg::CQ_CW'(dtq_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= '{func: in_func, task_id: in_task_id, interval_ms: in_interval_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wp_r <= (wp_r == dtq_pkg::CQ_AW'(dtq_pkg::CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop_ok) begin
        rp_r <= (rp_r == dtq_pkg::CQ_AW'(dtq_pkg::CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/dtq_res_queue.sv]
module dtq_res_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dtq_pkg::res_t res_in,
  output logic          full,
  output logic          empty,
  input  logic          pop,
  output dtq_pkg::res_t res_out
);

  dtq_pkg::res_t             q_r [dtq_pkg::RESQ_DEPTH];
  logic [dtq_pkg::RQ_AW-1:0] wp_r, rp_r;
  logic [dtq_pkg::RQ_CW-1:0] cnt_r;
  logic                      push_ok, pop_ok;

  assign full    = (cnt_r == dtq_pkg::RQ_CW'(dtq_pkg::RESQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign res_out = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wp_r <= (wp_r == dtq_pkg::RQ_AW'(dtq_pkg::RESQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop_ok) begin
        rp_r <= (rp_r == dtq_pkg::RQ_AW'(dtq_pkg::RESQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/dtq_back.sv]
module dtq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  dtq_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic [9:0]    tick_ms,
  output logic          res_push,
  output dtq_pkg::res_t res_data,
  input  logic          res_full
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INS   = 4'd1;
  localparam logic [3:0] S_RESP  = 4'd2;
  localparam logic [3:0] S_DSCAN = 4'd3;
  localparam logic [3:0] S_DPICK = 4'd4;
  localparam logic [3:0] S_PSCAN = 4'd5;
  localparam logic [3:0] S_PPICK = 4'd6;
  localparam logic [3:0] S_FLUSH = 4'd7;

  localparam int DD = dtq_pkg::DELAYED_DEPTH;
  localparam int PD = dtq_pkg::PERIODIC_DEPTH;

  // Stores
  logic [DD-1:0] d_vld_r;
  logic [7:0]    d_id_r  [DD];
  logic [31:0]   d_due_r [DD];
  logic [15:0]   d_seq_r [DD];
  logic [PD-1:0] p_vld_r;
  logic [PD-1:0] done_r;
  logic [7:0]    p_id_r  [PD];
  logic [31:0]   p_due_r [PD];
  logic [15:0]   p_seq_r [PD];
  logic [15:0]   p_per_r [PD];
  logic [dtq_pkg::TASK_IDS-1:0] marks_r;

  // Control
  logic [3:0]                state_r, state_nxt;
  dtq_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [dtq_pkg::IDX_W-1:0] idx_r, idx_nxt, best_idx_r, best_idx_nxt;
  logic                      found_r, found_nxt;
  logic [31:0]               best_key_r, best_key_nxt;
  logic [15:0]               best_seq_r, best_seq_nxt;
  logic [7:0]                best_id_r, best_id_nxt;
  logic [15:0]               best_per_r, best_per_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  dtq_pkg::res_t             pend_r, pend_nxt, resp_r, resp_nxt;
  logic [dtq_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [31:0]               now_r, now_nxt;
  logic [15:0]               seq_r, seq_nxt;

  // Strobes
  logic d_ins, p_ins, d_kill, p_kill, p_resched, mark_set, done_clr, done_set;

  logic [dtq_pkg::DLY_AW-1:0] d_sel, d_best;
  logic [dtq_pkg::PER_AW-1:0] p_sel, p_best;
  logic [31:0]                d_key, p_key;
  logic                       d_cand, p_cand, d_end, p_end;
  logic                       ins_dly, ins_free, ins_end, mark_hit;
  logic [dtq_pkg::CNT_W-1:0]  n_inc;

  assign d_sel  = idx_r[dtq_pkg::DLY_AW-1:0];
  assign p_sel  = idx_r[dtq_pkg::PER_AW-1:0];
  assign d_best = best_idx_r[dtq_pkg::DLY_AW-1:0];
  assign p_best = best_idx_r[dtq_pkg::PER_AW-1:0];
  assign d_key  = dtq_pkg::rel_key(d_due_r[d_sel], now_r);
  assign p_key  = dtq_pkg::rel_key(p_due_r[p_sel], now_r);
  assign d_cand = d_vld_r[d_sel] && dtq_pkg::is_due(d_key) &&
                  (!found_r || dtq_pkg::earlier(d_key, d_seq_r[d_sel], best_key_r, best_seq_r));
  assign p_cand = p_vld_r[p_sel] && !done_r[p_sel] && dtq_pkg::is_due(p_key) &&
                  (!found_r || dtq_pkg::earlier(p_key, p_seq_r[p_sel], best_key_r, best_seq_r));
  assign d_end  = (idx_r == dtq_pkg::IDX_W'(DD - 1));
  assign p_end  = (idx_r == dtq_pkg::IDX_W'(PD - 1));
  assign ins_dly  = (cmd_r.func == dtq_pkg::FUNC_ADD_DLY);
  assign ins_free = ins_dly ? !d_vld_r[d_sel] : !p_vld_r[p_sel];
  assign ins_end  = ins_dly ? d_end : p_end;
  assign mark_hit = dtq_pkg::id_ok(best_id_r) &&
                    marks_r[dtq_pkg::MARK_AW'(best_id_r)];
  assign n_inc    = n_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_key_nxt = best_key_r;
    best_seq_nxt = best_seq_r;
    best_id_nxt  = best_id_r;
    best_per_nxt = best_per_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    resp_nxt     = resp_r;
    n_nxt        = n_r;
    now_nxt      = now_r;
    seq_nxt      = seq_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_data     = pend_r;
    d_ins        = 1'b0;
    p_ins        = 1'b0;
    d_kill       = 1'b0;
    p_kill       = 1'b0;
    p_resched    = 1'b0;
    mark_set     = 1'b0;
    done_clr     = 1'b0;
    done_set     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          unique case (cmd.func)
            dtq_pkg::FUNC_TICK: begin
              now_nxt   = now_r + 32'(tick_ms);
              n_nxt     = '0;
              done_clr  = 1'b1;
              state_nxt = S_DSCAN;
            end
            dtq_pkg::FUNC_ADD_DLY, dtq_pkg::FUNC_ADD_PER: begin
              state_nxt = S_INS;
            end
            dtq_pkg::FUNC_CANCEL: begin
              mark_set  = 1'b1;
              resp_nxt  = '{kind: dtq_pkg::KIND_STATUS, fired_task: cmd.task_id,
                            status: dtq_pkg::ST_OK, last: 1'b1};
              state_nxt = S_RESP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        resp_nxt = '{kind: dtq_pkg::KIND_STATUS, fired_task: cmd_r.task_id,
                     status: dtq_pkg::ST_OK, last: 1'b1};
        if (ins_free) begin
          d_ins     = ins_dly;
          p_ins     = !ins_dly;
          seq_nxt   = seq_r + 1'b1;
          state_nxt = S_RESP;
        end else if (ins_end) begin
          resp_nxt.status = dtq_pkg::ST_FULL;
          state_nxt       = S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RESP: begin
        res_data = resp_r;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DSCAN: begin
        if (d_cand) begin
          found_nxt    = 1'b1;
          best_idx_nxt = idx_r;
          best_key_nxt = d_key;
          best_seq_nxt = d_seq_r[d_sel];
          best_id_nxt  = d_id_r[d_sel];
        end
        if (d_end) begin
          state_nxt = S_DPICK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DPICK: begin
        if (!found_r) begin
          idx_nxt   = '0;
          state_nxt = S_PSCAN;
        end else if (!(pend_vld_r && res_full)) begin
          res_push     = pend_vld_r;
          d_kill       = 1'b1;
          pend_vld_nxt = 1'b1;
          pend_nxt     = '{kind: dtq_pkg::KIND_DELAYED, fired_task: best_id_r,
                           status: dtq_pkg::ST_OK, last: 1'b0};
          n_nxt        = n_inc;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          state_nxt    = (n_inc == dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS)) ? S_FLUSH : S_DSCAN;
        end
      end
      S_PSCAN: begin
        if (p_cand) begin
          found_nxt    = 1'b1;
          best_idx_nxt = idx_r;
          best_key_nxt = p_key;
          best_seq_nxt = p_seq_r[p_sel];
          best_id_nxt  = p_id_r[p_sel];
          best_per_nxt = p_per_r[p_sel];
        end
        if (p_end) begin
          state_nxt = S_PPICK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_PPICK: begin
        if (!found_r) begin
          state_nxt = S_FLUSH;
        end else if (mark_hit) begin
          // cancelled: drop silently
          done_set  = 1'b1;
          p_kill    = 1'b1;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_PSCAN;
        end else if (!(pend_vld_r && res_full)) begin
          res_push     = pend_vld_r;
          done_set     = 1'b1;
          p_resched    = 1'b1;
          seq_nxt      = seq_r + 1'b1;
          pend_vld_nxt = 1'b1;
          pend_nxt     = '{kind: dtq_pkg::KIND_PERIODIC, fired_task: best_id_r,
                           status: dtq_pkg::ST_OK, last: 1'b0};
          n_nxt        = n_inc;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          state_nxt    = (n_inc == dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS)) ? S_FLUSH : S_PSCAN;
        end
      end
      S_FLUSH: begin
        res_data.last = 1'b1;
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (!res_full) begin
          res_push     = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      found_r    <= 1'b0;
      idx_r      <= '0;
      n_r        <= '0;
      now_r      <= '0;
      seq_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      found_r    <= found_nxt;
      idx_r      <= idx_nxt;
      n_r        <= n_nxt;
      now_r      <= now_nxt;
      seq_r      <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    best_seq_r <= best_seq_nxt;
    best_id_r  <= best_id_nxt;
    best_per_r <= best_per_nxt;
    pend_r     <= pend_nxt;
    resp_r     <= resp_nxt;
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (d_ins) begin
      d_id_r[d_sel]  <= cmd_r.task_id;
      d_due_r[d_sel] <= now_r + 32'(cmd_r.interval_ms);
      d_seq_r[d_sel] <= seq_r;
    end
    if (p_ins) begin
      p_id_r[p_sel]  <= cmd_r.task_id;
      p_due_r[p_sel] <= now_r + 32'(cmd_r.interval_ms);
      p_seq_r[p_sel] <= seq_r;
      p_per_r[p_sel] <= cmd_r.interval_ms;
    end else if (p_resched) begin
      p_due_r[p_best] <= now_r + 32'(best_per_r);
      p_seq_r[p_best] <= seq_r;
    end
  end

  // Valid, done and cancel bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= '0;
      p_vld_r <= '0;
      done_r  <= '0;
      marks_r <= '0;
    end else begin
      if (d_ins) begin
        d_vld_r[d_sel] <= 1'b1;
      end else if (d_kill) begin
        d_vld_r[d_best] <= 1'b0;
      end
      if (p_ins) begin
        p_vld_r[p_sel] <= 1'b1;
      end else if (p_kill) begin
        p_vld_r[p_best] <= 1'b0;
      end
      if (done_clr) begin
        done_r <= '0;
      end else if (done_set) begin
        done_r[p_best] <= 1'b1;
      end
      if (mark_set && dtq_pkg::id_ok(cmd.task_id)) begin
        marks_r[dtq_pkg::MARK_AW'(cmd.task_id)] <= 1'b1;
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("pending result left behind at idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS))
    else $error("result count beyond limit");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cmd_valid && cmd.func == dtq_pkg::FUNC_TICK)
      |=> now_r == $past(now_r) + 32'($past(tick_ms)))
    else $error("time not advanced by tick");

endmodule

[rtl/core/deadline_timer_queue.sv]
// Channel   | Direction | Handshake                      | Payload
// input     | in        | in_push / in_full              | in_func, in_task_id, in_interval_ms
// result    | out       | out_pop / out_empty            | out_kind, out_fired_task, out_status,
//           |           |                                |   out_last
// config    | in/out    | psel, penable, pwrite, pready  | paddr, pwdata, prdata (tick_ms at 0x0)
//
// Order: a cancel reaches the result port through the response state and the result
// queue; a submit first searches the store linearly for a free slot, then responds.
// A tick passes the idle state, then per store one full scan of every entry and one pick
// for every fired or dropped task, each pick followed by a fresh scan, and a closing
// flush state ends it.
// Reset: synchronous, active low; all stores empty, no clearing pass needed.
// Stalls: a two-entry command queue and a four-entry result queue decouple the
// engine from both channels; the engine holds while a result waits on a full result queue.
module deadline_timer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_interval_ms,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_fired_task,
  output logic        out_status,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dtq_pkg::cmd_t cmd;
  dtq_pkg::res_t res_data, res_out;
  logic          cmd_valid, cmd_pop, res_push, res_full;
  logic [9:0]    tick_ms;

  // Accept transactions and hold the tick register
  dtq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_task_id     (in_task_id),
    .in_interval_ms (in_interval_ms),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .tick_ms        (tick_ms)
  );

  // Scan the stores, fire and reschedule
  dtq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .tick_ms   (tick_ms),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  // Hold finished results until the consumer takes them
  dtq_res_queue u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .res_in  (res_data),
    .full    (res_full),
    .empty   (out_empty),
    .pop     (out_pop),
    .res_out (res_out)
  );

  assign out_kind       = res_out.kind;
  assign out_fired_task = res_out.fired_task;
  assign out_status     = res_out.status;
  assign out_last       = res_out.last;

endmodule
